>>> design/ldm_pkg.sv
// shared types, codes and font table of the led matrix draw engine
package ldm_pkg;

    // command modes
    localparam logic [2:0] MODE_SET   = 3'd0;
    localparam logic [2:0] MODE_GET   = 3'd1;
    localparam logic [2:0] MODE_FILL  = 3'd2;
    localparam logic [2:0] MODE_GLYPH = 3'd3;
    localparam logic [2:0] MODE_CLEAR = 3'd4;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_BYTES   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE = 2'd1;

    localparam logic [2:0] ROW_BYTES_RESET   = 3'd1;
    localparam logic [4:0] ROWS_IN_USE_RESET = 5'd8;

    // default digit font, one byte per glyph row, bit 0 is the leftmost dot
    localparam int FONT_GLYPHS = 10;
    localparam int FONT_ROWS   = 10;
    localparam logic [7:0] FONT_BITS [0:FONT_GLYPHS*FONT_ROWS-1] = '{
        8'h1F, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h1F, 8'h00,
        8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h00,
        8'h1F, 8'h10, 8'h10, 8'h10, 8'h1F, 8'h01, 8'h01, 8'h01, 8'h1F, 8'h00,
        8'h1F, 8'h10, 8'h10, 8'h10, 8'h1F, 8'h10, 8'h10, 8'h10, 8'h1F, 8'h00,
        8'h11, 8'h11, 8'h11, 8'h11, 8'h1F, 8'h10, 8'h10, 8'h10, 8'h10, 8'h00,
        8'h1F, 8'h01, 8'h01, 8'h01, 8'h1F, 8'h10, 8'h10, 8'h10, 8'h1F, 8'h00,
        8'h1F, 8'h01, 8'h01, 8'h01, 8'h1F, 8'h11, 8'h11, 8'h11, 8'h1F, 8'h00,
        8'h1F, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h00,
        8'h1F, 8'h11, 8'h11, 8'h11, 8'h1F, 8'h11, 8'h11, 8'h11, 8'h1F, 8'h00,
        8'h1F, 8'h11, 8'h11, 8'h11, 8'h1F, 8'h10, 8'h10, 8'h10, 8'h1F, 8'h00
    };

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] span_w;
        logic [7:0] span_h;
        logic       level;
        logic [7:0] glyph_code;
    } cmd_t;

    typedef struct packed {
        logic pixel_level;
        logic in_bounds;
    } res_t;

    // glyph row lookup; rows and glyphs beyond the default font are blank
    function automatic logic [7:0] font_row(input logic [7:0] code, input logic [7:0] row);
        int idx;
        idx = int'(code) * FONT_ROWS + int'(row);
        if (int'(code) < FONT_GLYPHS && int'(row) < FONT_ROWS)
        begin
            return FONT_BITS[idx];
        end
        return 8'h00;
    endfunction

endpackage

>>> design/ldm_ram.sv
// generic single write port ram with registered read
module ldm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/led_matrix_draw_engine.sv
// top level of the led matrix draw engine: sequencer, dot walker and store
//
// usage
// - command channel: an item (cmd) is taken at a rising edge with start high
//   and busy low; busy stays high while the item is being worked on
// - result channel: done is high for exactly one cycle with result valid;
//   every item gives one result, the receiver cannot stall it
// - config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
//   is row_bytes, index 1 is rows_in_use, other indexes are dropped;
//   cfg_ready is always high, writes belong in idle periods
// - timing: one dot is visited per cycle through a shared locate and
//   read-modify-write unit on the store's single write port
//   set and get: the dot is located, then read and updated in the second stage
//   fill and glyph: w*h or GLYPH_WIDTH*GLYPH_HEIGHT dots, walked row by row
//   clear, empty fills, unknown glyph codes and unused modes: answered from idle
// - reset: store reads as all dots off through per-byte valid bits, which a
//   clear item also drops; row_bytes 1, rows_in_use 8
module led_matrix_draw_engine #(
    parameter int MAX_ROW_BYTES = 4,
    parameter int MAX_ROWS      = 16,
    parameter int GLYPH_WIDTH   = 6,
    parameter int GLYPH_HEIGHT  = 10,
    parameter int GLYPH_COUNT   = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ldm_pkg::cmd_t                       cmd,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ldm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ldm_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                done,
    output ldm_pkg::res_t                       result
);

    import ldm_pkg::*;

    // store geometry
    localparam int DEPTH = MAX_ROW_BYTES * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = 10;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    // control registers
    state_t             state_reg, state_next;
    logic [2:0]         row_bytes_reg, row_bytes_next;
    logic [4:0]         rows_reg, rows_next;
    logic [DEPTH-1:0]   valid_reg, valid_next;
    logic               s2_valid_reg, s2_valid_next;
    logic               fwd_en_reg, fwd_en_next;
    logic               done_reg, done_next;

    // payload registers
    logic [2:0]         mode_reg, mode_next;
    logic [7:0]         x0_reg, x0_next;
    logic [7:0]         y0_reg, y0_next;
    logic [7:0]         w_reg, w_next;
    logic [7:0]         h_reg, h_next;
    logic               lvl_reg, lvl_next;
    logic [7:0]         code_reg, code_next;
    logic [7:0]         dx_reg, dx_next;
    logic [7:0]         dy_reg, dy_next;
    logic [AW-1:0]      s2_addr_reg, s2_addr_next;
    logic [2:0]         s2_bit_reg, s2_bit_next;
    logic               s2_level_reg, s2_level_next;
    logic               s2_write_reg, s2_write_next;
    logic [AW-1:0]      fwd_addr_reg, fwd_addr_next;
    logic [7:0]         fwd_data_reg, fwd_data_next;
    logic               pix_reg, pix_next;
    logic               inb_reg, inb_next;

    // locate unit
    logic [3:0]         eff_rb;
    logic [5:0]         eff_rows;
    logic [7:0]         cx, cy;
    logic [IW-1:0]      byte_idx;
    logic               dot_inb;
    logic [7:0]         glyph_bits;
    logic               dot_level;
    logic               last_dot;

    // read-modify-write stage
    logic [7:0]         ram_rd;
    logic [7:0]         cur_byte;
    logic [7:0]         new_byte;
    logic               ram_we;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = '{pixel_level: pix_reg, in_bounds: inb_reg};

    // effective geometry saturates at the store size
    assign eff_rb   = ({1'b0, row_bytes_reg} > 4'(MAX_ROW_BYTES))
                      ? 4'(MAX_ROW_BYTES) : {1'b0, row_bytes_reg};
    assign eff_rows = ({1'b0, rows_reg} > 6'(MAX_ROWS))
                      ? 6'(MAX_ROWS) : {1'b0, rows_reg};

    // coordinates wrap at 8 bits
    assign cx       = x0_reg + dx_reg;
    assign cy       = y0_reg + dy_reg;
    assign byte_idx = IW'(cy[5:0]) * IW'(eff_rb) + IW'(cx[7:3]);
    assign dot_inb  = ({1'b0, cx} < 9'({eff_rb, 3'b000}))
                      && (cy < 8'(eff_rows))
                      && (int'(byte_idx) < DEPTH);

    assign glyph_bits = font_row(code_reg, dy_reg);
    assign dot_level  = (mode_reg == MODE_GLYPH) ? glyph_bits[dx_reg[2:0]] : lvl_reg;
    assign last_dot   = (dx_reg == w_reg - 8'd1) && (dy_reg == h_reg - 8'd1);

    // byte seen by the second stage: last write forwarded, unwritten reads 0
    always_comb
    begin
        if (fwd_en_reg && (fwd_addr_reg == s2_addr_reg))
        begin
            cur_byte = fwd_data_reg;
        end
        else if (valid_reg[s2_addr_reg])
        begin
            cur_byte = ram_rd;
        end
        else
        begin
            cur_byte = 8'h00;
        end
        new_byte              = cur_byte;
        new_byte[s2_bit_reg]  = s2_level_reg;
    end

    assign ram_we = s2_valid_reg && s2_write_reg;

    ldm_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (s2_addr_reg),
        .wr_data (new_byte),
        .rd_addr (byte_idx[AW-1:0]),
        .rd_data (ram_rd)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        row_bytes_next = row_bytes_reg;
        rows_next      = rows_reg;
        valid_next     = valid_reg;
        s2_valid_next  = 1'b0;
        fwd_en_next    = ram_we;
        done_next      = 1'b0;
        mode_next      = mode_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        lvl_next       = lvl_reg;
        code_next      = code_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        s2_addr_next   = byte_idx[AW-1:0];
        s2_bit_next    = cx[2:0];
        s2_level_next  = dot_level;
        s2_write_next  = (mode_reg != MODE_GET);
        fwd_addr_next  = s2_addr_reg;
        fwd_data_next  = new_byte;
        pix_next       = pix_reg;
        inb_next       = inb_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROW_BYTES:   row_bytes_next = cfg_data[2:0];
                REG_ROWS_IN_USE: rows_next      = cfg_data[4:0];
                default:         ;
            endcase
        end

        // written byte gets its valid bit on write
        if (ram_we)
        begin
            valid_next[s2_addr_reg] = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mode_next = cmd.mode;
                    x0_next   = cmd.pos_x;
                    y0_next   = cmd.pos_y;
                    lvl_next  = cmd.level;
                    code_next = cmd.glyph_code;
                    dx_next   = 8'd0;
                    dy_next   = 8'd0;
                    pix_next  = 1'b0;
                    inb_next  = 1'b0;
                    w_next    = 8'd1;
                    h_next    = 8'd1;
                    case (cmd.mode)
                        MODE_SET, MODE_GET:
                        begin
                            state_next = ST_WALK;
                        end
                        MODE_FILL:
                        begin
                            w_next = cmd.span_w;
                            h_next = cmd.span_h;
                            if (cmd.span_w != 8'd0 && cmd.span_h != 8'd0)
                            begin
                                state_next = ST_WALK;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        MODE_GLYPH:
                        begin
                            w_next = 8'(GLYPH_WIDTH);
                            h_next = 8'(GLYPH_HEIGHT);
                            if (int'(cmd.glyph_code) < GLYPH_COUNT)
                            begin
                                state_next = ST_WALK;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            valid_next  = '0;
                            fwd_en_next = 1'b0;
                            done_next   = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // issue one dot, read lands in the second stage next cycle
                s2_valid_next = dot_inb;
                if (mode_reg inside {MODE_SET, MODE_GET})
                begin
                    inb_next = dot_inb;
                end
                if (last_dot)
                begin
                    state_next = ST_FLUSH;
                end
                else if (dx_reg == w_reg - 8'd1)
                begin
                    dx_next = 8'd0;
                    dy_next = dy_reg + 8'd1;
                end
                else
                begin
                    dx_next = dx_reg + 8'd1;
                end
            end
            ST_FLUSH:
            begin
                // last dot finishes in the second stage
                if (mode_reg == MODE_GET)
                begin
                    pix_next = s2_valid_reg && cur_byte[s2_bit_reg];
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_bytes_reg <= ROW_BYTES_RESET;
            rows_reg      <= ROWS_IN_USE_RESET;
            valid_reg     <= '0;
            s2_valid_reg  <= 1'b0;
            fwd_en_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_bytes_reg <= row_bytes_next;
            rows_reg      <= rows_next;
            valid_reg     <= valid_next;
            s2_valid_reg  <= s2_valid_next;
            fwd_en_reg    <= fwd_en_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        x0_reg       <= x0_next;
        y0_reg       <= y0_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        lvl_reg      <= lvl_next;
        code_reg     <= code_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        s2_addr_reg  <= s2_addr_next;
        s2_bit_reg   <= s2_bit_next;
        s2_level_reg <= s2_level_next;
        s2_write_reg <= s2_write_next;
        fwd_addr_reg <= fwd_addr_next;
        fwd_data_reg <= fwd_data_next;
        pix_reg      <= pix_next;
        inb_reg      <= inb_next;
    end

    // an accepted item either starts a walk or answers at once
    a_start_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item neither walked nor answered");

    // a result is only given with the sequencer in idle, never straight out of a walk
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == ST_IDLE && $past(state_reg) != ST_WALK))
        else $error("result strobe outside the end of an item");

    // the second stage only carries dots of an item in progress
    a_s2_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (state_reg == ST_WALK || state_reg == ST_FLUSH))
        else $error("store access while idle");

    // forwarding only follows a store write of the previous cycle
    a_fwd_write: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_en_reg |-> $past(ram_we))
        else $error("forwarded byte without a preceding write");

endmodule

>>> test/tb_top.sv
// self-checking testbench for the led matrix draw engine with a dot-level scoreboard
`timescale 1ns / 100ps

module tb_top;

    import ldm_pkg::*;

    // geometry the engine is built with
    localparam int MAX_RB      = 4;
    localparam int MAX_LINES   = 16;
    localparam int GLYPH_W     = 6;
    localparam int GLYPH_H     = 10;
    localparam int GLYPH_N     = 10;
    localparam int STORE_BYTES = MAX_RB * MAX_LINES;

    // modes the engine treats as no-ops
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    // register indexes the engine drops
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    // idle cycles allowed with nothing moving; must outlast a full 255 x 255 fill
    localparam int WATCHDOG_LIMIT = 300000;

    // digit font the predictor draws from, one byte per glyph row, bit 0 leftmost
    localparam bit [7:0] DIGIT_ROWS [0:GLYPH_N*GLYPH_H-1] = '{
        8'h1F, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h1F, 8'h00,
        8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h00,
        8'h1F, 8'h10, 8'h10, 8'h10, 8'h1F, 8'h01, 8'h01, 8'h01, 8'h1F, 8'h00,
        8'h1F, 8'h10, 8'h10, 8'h10, 8'h1F, 8'h10, 8'h10, 8'h10, 8'h1F, 8'h00,
        8'h11, 8'h11, 8'h11, 8'h11, 8'h1F, 8'h10, 8'h10, 8'h10, 8'h10, 8'h00,
        8'h1F, 8'h01, 8'h01, 8'h01, 8'h1F, 8'h10, 8'h10, 8'h10, 8'h1F, 8'h00,
        8'h1F, 8'h01, 8'h01, 8'h01, 8'h1F, 8'h11, 8'h11, 8'h11, 8'h1F, 8'h00,
        8'h1F, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h00,
        8'h1F, 8'h11, 8'h11, 8'h11, 8'h1F, 8'h11, 8'h11, 8'h11, 8'h1F, 8'h00,
        8'h1F, 8'h11, 8'h11, 8'h11, 8'h1F, 8'h10, 8'h10, 8'h10, 8'h1F, 8'h00
    };

    // mirror of the frame store plus the queue of readings still owed by the engine
    class frame_scoreboard;
        bit [7:0] dots [0:STORE_BYTES-1];
        bit [2:0] row_bytes;
        bit [4:0] rows_in_use;
        res_t     owed_readings [$];
        int unsigned errors;

        function new();
            foreach (dots[i])
                dots[i] = 8'h00;
            row_bytes   = ROW_BYTES_RESET;
            rows_in_use = ROWS_IN_USE_RESET;
            errors      = 0;
        endfunction

        function void write_reg(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_ROW_BYTES:   row_bytes   = data[2:0];
                REG_ROWS_IN_USE: rows_in_use = data;
                default: ;
            endcase
        endfunction

        // registers above range saturate at the built size
        function int unsigned lit_bytes();
            return (row_bytes > MAX_RB) ? MAX_RB : row_bytes;
        endfunction

        function int unsigned width_dots();
            return 8 * lit_bytes();
        endfunction

        function int unsigned height_dots();
            return (rows_in_use > MAX_LINES) ? MAX_LINES : rows_in_use;
        endfunction

        // byte holding dot (x, y), or 0 when the dot is off the matrix
        function bit find_byte(input int unsigned x, input int unsigned y,
                               output int unsigned byte_idx);
            byte_idx = 0;
            if (x >= width_dots() || y >= height_dots())
                return 1'b0;
            byte_idx = y * lit_bytes() + x / 8;
            return byte_idx < STORE_BYTES;
        endfunction

        // coordinates wrap at 8 bits before the bounds test
        function bit put_dot(input int unsigned x, input int unsigned y, input bit on);
            int unsigned byte_idx;
            if (!find_byte(x % 256, y % 256, byte_idx))
                return 1'b0;
            dots[byte_idx][x % 8] = on;
            return 1'b1;
        endfunction

        function void note_command(input cmd_t c);
            res_t        r;
            int unsigned byte_idx;
            bit          hit;
            r = '0;
            case (c.mode)
                MODE_SET:
                    r.in_bounds = put_dot(c.pos_x, c.pos_y, c.level);
                MODE_GET:
                    if (find_byte(c.pos_x, c.pos_y, byte_idx))
                    begin
                        r.in_bounds   = 1'b1;
                        r.pixel_level = dots[byte_idx][c.pos_x % 8];
                    end
                MODE_FILL:
                    for (int dy = 0; dy < c.span_h; dy++)
                        for (int dx = 0; dx < c.span_w; dx++)
                            hit = put_dot(c.pos_x + dx, c.pos_y + dy, c.level);
                MODE_GLYPH:
                    if (c.glyph_code < GLYPH_N)
                        for (int dy = 0; dy < GLYPH_H; dy++)
                            for (int dx = 0; dx < GLYPH_W; dx++)
                                hit = put_dot(c.pos_x + dx, c.pos_y + dy,
                                    DIGIT_ROWS[c.glyph_code * GLYPH_H + dy][dx]);
                MODE_CLEAR:
                    foreach (dots[i])
                        dots[i] = 8'h00;
                default: ;
            endcase
            owed_readings.push_back(r);
        endfunction

        function void check_reading(input res_t got);
            res_t want;
            if (owed_readings.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %b", $time, got);
                errors++;
                return;
            end
            want = owed_readings.pop_front();
            if (got.pixel_level !== want.pixel_level)
            begin
                $display("%0t: pixel_level mismatch, expected %b, actual %b",
                         $time, want.pixel_level, got.pixel_level);
                errors++;
            end
            if (got.in_bounds !== want.in_bounds)
            begin
                $display("%0t: in_bounds mismatch, expected %b, actual %b",
                         $time, want.in_bounds, got.in_bounds);
                errors++;
            end
        endfunction

        function int unsigned owed();
            return owed_readings.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    cmd_t                   cmd;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   done;
    res_t                   result;

    frame_scoreboard sb = new();
    int unsigned     idle_cycles;

    led_matrix_draw_engine #(
        .MAX_ROW_BYTES(MAX_RB),
        .MAX_ROWS(MAX_LINES),
        .GLYPH_WIDTH(GLYPH_W),
        .GLYPH_HEIGHT(GLYPH_H),
        .GLYPH_COUNT(GLYPH_N)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .done(done),
        .result(result)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // results cannot be held off, so every strobe is checked at the edge that ends it
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_reading(result);
    end

    // watchdog: any accepted item, result or register write counts as progress
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && busy === 1'b0) || done === 1'b1 || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    function automatic cmd_t make_cmd(input logic [2:0] mode, input logic [7:0] x,
                                      input logic [7:0] y, input logic [7:0] w,
                                      input logic [7:0] h, input logic lvl,
                                      input logic [7:0] code);
        cmd_t c;
        c.mode       = mode;
        c.pos_x      = x;
        c.pos_y      = y;
        c.span_w     = w;
        c.span_h     = h;
        c.level      = lvl;
        c.glyph_code = code;
        return c;
    endfunction

    // random command biased toward the live matrix area, small rectangles and real digits
    function automatic cmd_t random_command(input int unsigned wd, input int unsigned ht);
        cmd_t        c;
        int unsigned roll;
        c = make_cmd(3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 1'($urandom), 8'($urandom));
        roll = $urandom_range(0, 99);
        if (roll < 20)
            c.mode = MODE_SET;
        else if (roll < 46)
            c.mode = MODE_GET;
        else if (roll < 62)
            c.mode = MODE_FILL;
        else if (roll < 80)
            c.mode = MODE_GLYPH;
        else if (roll < 84)
            c.mode = MODE_CLEAR;
        else if (roll < 89)
            c.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        else
            c.mode = MODE_GET;

        // mostly inside or just past the edge, some near the 255 wrap, rest anywhere
        roll = $urandom_range(0, 99);
        if (roll < 75)
        begin
            c.pos_x = 8'($urandom_range(0, wd + 3));
            c.pos_y = 8'($urandom_range(0, ht + 2));
        end
        else if (roll < 85)
        begin
            c.pos_x = 8'($urandom_range(240, 255));
            c.pos_y = 8'($urandom_range(244, 255));
        end

        // fill walks one dot per cycle, so big rectangles stay rare
        roll = $urandom_range(0, 999);
        if (roll < 880)
        begin
            c.span_w = 8'($urandom_range(0, 12));
            c.span_h = 8'($urandom_range(0, 12));
        end
        else if (roll < 935)
            c.span_h = 8'($urandom_range(0, 2));
        else if (roll < 990)
            c.span_w = 8'($urandom_range(0, 2));
        else if (roll < 997)
        begin
            c.span_w = 8'($urandom_range(0, 40));
            c.span_h = 8'($urandom_range(0, 40));
        end

        if ($urandom_range(0, 99) < 85)
            c.glyph_code = 8'($urandom_range(0, GLYPH_N - 1));
        return c;
    endfunction

    // hold start high until the engine takes the item
    task automatic send_command(input cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_command(c);
    endtask

    // drop start and wait until every owed reading is in and the engine is idle
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.owed() != 0 || busy !== 1'b0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.write_reg(index, data);
        @(posedge clk);
    endtask

    task automatic run_directed();
        // reset layout, 8 x 8
        send_command(make_cmd(MODE_SET, 8'd7, 8'd7, 8'd0, 8'd0, 1'b1, 8'd0));
        send_command(make_cmd(MODE_SET, 8'd8, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0));
        send_command(make_cmd(MODE_GET, 8'd7, 8'd7, 8'd0, 8'd0, 1'b0, 8'd0));
        send_command(make_cmd(MODE_GET, 8'd0, 8'd8, 8'd0, 8'd0, 1'b0, 8'd0));
        drain_results();

        // widest and tallest layout; the old lit byte now reads as dot (31, 1)
        write_reg(REG_ROW_BYTES, 5'd4);
        write_reg(REG_ROWS_IN_USE, 5'd16);
        send_command(make_cmd(MODE_GET, 8'd31, 8'd1, 8'd0, 8'd0, 1'b0, 8'd0));
        send_command(make_cmd(MODE_SET, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0));
        send_command(make_cmd(MODE_SET, 8'd31, 8'd15, 8'd0, 8'd0, 1'b1, 8'd0));
        send_command(make_cmd(MODE_GET, 8'd31, 8'd15, 8'd0, 8'd0, 1'b0, 8'd0));
        send_command(make_cmd(MODE_SET, 8'd32, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0));
        send_command(make_cmd(MODE_SET, 8'd255, 8'd255, 8'd0, 8'd0, 1'b1, 8'd0));
        // rectangle wrapping past 255 in both directions
        send_command(make_cmd(MODE_FILL, 8'd250, 8'd254, 8'd10, 8'd4, 1'b1, 8'd0));
        send_command(make_cmd(MODE_GET, 8'd2, 8'd1, 8'd0, 8'd0, 1'b0, 8'd0));
        // empty rectangles
        send_command(make_cmd(MODE_FILL, 8'd1, 8'd1, 8'd0, 8'd9, 1'b1, 8'd0));
        send_command(make_cmd(MODE_FILL, 8'd1, 8'd1, 8'd9, 8'd0, 1'b1, 8'd0));
        // glyph in place, glyph wrapping, glyph codes past the font
        send_command(make_cmd(MODE_GLYPH, 8'd0, 8'd2, 8'd0, 8'd0, 1'b0, 8'd8));
        send_command(make_cmd(MODE_GET, 8'd1, 8'd3, 8'd0, 8'd0, 1'b0, 8'd0));
        send_command(make_cmd(MODE_GLYPH, 8'd253, 8'd14, 8'd0, 8'd0, 1'b0, 8'd0));
        send_command(make_cmd(MODE_GLYPH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd10));
        send_command(make_cmd(MODE_GLYPH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd255));
        // unused mode with every other field set
        send_command(make_cmd(MODE_SPARE_FIRST, 8'd3, 8'd3, 8'd255, 8'd255, 1'b1, 8'd255));
        send_command(make_cmd(MODE_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0));
        send_command(make_cmd(MODE_GET, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0));
        // largest rectangle covers the whole matrix
        send_command(make_cmd(MODE_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1, 8'd0));
        send_command(make_cmd(MODE_GET, 8'd17, 8'd9, 8'd0, 8'd0, 1'b0, 8'd0));
        send_command(make_cmd(MODE_CLEAR, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255));
    endtask

    // random items in bursts with random gaps, now and then waiting for the engine to drain
    task automatic run_random(input int unsigned count);
        int burst_left;
        int unsigned gap;
        int unsigned roll;
        burst_left = $urandom_range(1, 16);
        repeat (count)
        begin
            send_command(random_command(sb.width_dots(), sb.height_dots()));
            burst_left--;
            if ($urandom_range(0, 99) < 2)
                drain_results();
            else if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 24);
                roll = $urandom_range(0, 3);
                if (roll == 0)
                    gap = 0;
                else if (roll == 3)
                    gap = $urandom_range(7, 80);
                else
                    gap = $urandom_range(1, 6);
                if (gap != 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    // layouts per phase: in range, saturated, empty; data covers every bit both ways
    localparam int PHASES = 7;
    localparam logic [CFG_DATA_W-1:0] PHASE_ROW_BYTES [0:PHASES-1] =
        '{5'd1, 5'd4, 5'd2, 5'd31, 5'd0, 5'd3, 5'd12};
    localparam logic [CFG_DATA_W-1:0] PHASE_ROWS [0:PHASES-1] =
        '{5'd8, 5'd16, 5'd1, 5'd31, 5'd10, 5'd0, 5'd17};
    localparam int PHASE_ITEMS [0:PHASES-1] = '{320, 320, 280, 320, 60, 60, 320};

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int p = 0; p < PHASES; p++)
        begin
            // layout changes only with the engine idle and nothing owed
            drain_results();
            write_reg(REG_ROW_BYTES, PHASE_ROW_BYTES[p]);
            write_reg(REG_ROWS_IN_USE, PHASE_ROWS[p]);
            write_reg((p % 2 == 0) ? REG_SPARE_A : REG_SPARE_B, 5'($urandom));
            run_random(PHASE_ITEMS[p]);
        end

        // let the last items finish, then watch for stray strobes over one glyph time
        drain_results();
        repeat (GLYPH_W * GLYPH_H + 10) @(posedge clk);
        if (sb.owed() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.owed());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
design/ldm_pkg.sv
design/ldm_ram.sv
design/led_matrix_draw_engine.sv
test/tb_top.sv
